/* src/ppca_pkg.sv */
package ppca_pkg;

    localparam int SOURCES      = 8;
    localparam int HANDLE_WIDTH = 8;
    localparam int SRC_W        = $clog2(SOURCES);
    localparam int WIN_W        = $clog2(SOURCES + 1);
    localparam int KIND_W       = 3;

    localparam logic [WIN_W-1:0] WINNER_NONE = WIN_W'(SOURCES);

    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOTO_XY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PATH_AN = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STOP    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BAD     = 3'd7;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_SUBMIT     = 4'd1,
        OP_CANCEL     = 4'd2,
        OP_CANCEL_ALL = 4'd3,
        OP_PAUSE_ON   = 4'd4,
        OP_PAUSE_OFF  = 4'd5,
        OP_PAUSE_TGL  = 4'd6,
        OP_ESTOP_SET  = 4'd7,
        OP_ESTOP_CLR  = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]              opcode;
        logic [SRC_W-1:0]        source;
        logic [KIND_W-1:0]       cmd_kind;
        logic [HANDLE_WIDTH-1:0] cmd_handle;
        logic                    preempt;
        logic                    motion_done;
        logic                    motion_tracking;
    } t_in_word;

    typedef struct packed {
        logic                    issue_valid;
        logic [KIND_W-1:0]       issue_kind;
        logic [HANDLE_WIDTH-1:0] issue_handle;
        logic [SRC_W-1:0]        issue_source;
        logic                    stop_request;
        logic                    advance_motion;
        logic [WIN_W-1:0]        winner;
        logic                    paused;
        logic                    estopped;
        logic                    idle;
    } t_out_word;

    typedef struct packed {
        logic exec;
    } t_ctl_cmd;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } t_state;

endpackage

/* src/ppca_ctrl.sv */
module ppca_ctrl
    import ppca_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_out_valid = (r_state == ST_FULL);
        o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
        o_cmd.exec  = i_in_valid && o_in_ready;
        n_state     = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (o_cmd.exec) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (!o_cmd.exec && i_out_ready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

endmodule

/* src/ppca_datapath.sv */
module ppca_datapath
    import ppca_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_in_word  i_in_word,
    output t_out_word o_out_word
);

    logic [SOURCES-1:0]      r_active;
    logic [SOURCES-1:0]      r_running;
    logic [KIND_W-1:0]       r_kind   [SOURCES];
    logic [HANDLE_WIDTH-1:0] r_handle [SOURCES];
    logic [WIN_W-1:0]        r_winner;
    logic                    r_pause;
    logic                    r_estop;
    t_out_word               r_res;

    logic [SOURCES-1:0]      n_active;
    logic [SOURCES-1:0]      n_running;
    logic [KIND_W-1:0]       n_kind   [SOURCES];
    logic [WIN_W-1:0]        n_winner;
    logic                    n_pause;
    logic                    n_estop;
    logic                    n_handle_we;
    t_out_word               n_res;

    logic                    has_best;
    logic [SRC_W-1:0]        best;
    logic [KIND_W-1:0]       best_kind;
    logic                    any_elig;
    logic [WIN_W-1:0]        src_w;

    always_comb begin
        has_best = 1'b0;
        best     = '0;
        for (int i = 0; i < SOURCES; i++) begin
            if (r_active[i] && r_kind[i] != KIND_NONE) begin
                has_best = 1'b1;
                best     = SRC_W'(i);
            end
        end
    end

    assign best_kind = r_kind[best];
    assign src_w     = WIN_W'(i_in_word.source);

    always_comb begin
        n_active    = r_active;
        n_running   = r_running;
        n_kind      = r_kind;
        n_winner    = r_winner;
        n_pause     = r_pause;
        n_estop     = r_estop;
        n_handle_we = 1'b0;
        n_res       = '0;
        any_elig    = 1'b0;

        unique case (t_op'(i_in_word.opcode))
            OP_TICK: begin
                if (r_estop || r_pause) begin
                    if (r_winner != WINNER_NONE) begin
                        n_res.stop_request = 1'b1;
                        n_winner           = WINNER_NONE;
                    end
                    n_running = '0;
                end else if (!has_best) begin
                    n_res.stop_request   = i_in_word.motion_tracking;
                    n_res.advance_motion = 1'b1;
                    n_winner             = WINNER_NONE;
                end else begin
                    if (r_winner != WIN_W'(best) || !r_running[best]) begin
                        n_res.issue_valid  = 1'b1;
                        n_res.issue_kind   = best_kind;
                        n_res.issue_handle = r_handle[best];
                        n_res.issue_source = best;
                        n_winner           = WIN_W'(best);
                        n_running[best]    = 1'b1;
                    end
                    if (best_kind == KIND_STOP) begin
                        n_active[best]  = 1'b0;
                        n_running[best] = 1'b0;
                        n_winner        = WINNER_NONE;
                    end else begin
                        n_res.advance_motion = 1'b1;
                        if (best_kind >= KIND_GOTO_XY && best_kind <= KIND_PATH_AN
                            && i_in_word.motion_done) begin
                            n_active[best]  = 1'b0;
                            n_running[best] = 1'b0;
                            n_winner        = WINNER_NONE;
                        end
                    end
                end
            end
            OP_SUBMIT: begin
                if (i_in_word.cmd_kind != KIND_BAD) begin
                    if (i_in_word.preempt) begin
                        for (int i = 0; i < SOURCES; i++) begin
                            if (SRC_W'(i) < i_in_word.source) begin
                                n_active[i]  = 1'b0;
                                n_running[i] = 1'b0;
                            end
                        end
                        if (r_winner != WINNER_NONE && r_winner < src_w) begin
                            n_winner = WINNER_NONE;
                        end
                    end
                    n_kind[i_in_word.source]    = i_in_word.cmd_kind;
                    n_active[i_in_word.source]  = 1'b1;
                    n_running[i_in_word.source] = 1'b0;
                    n_handle_we                 = 1'b1;
                end
            end
            OP_CANCEL: begin
                n_active[i_in_word.source]  = 1'b0;
                n_running[i_in_word.source] = 1'b0;
                if (r_winner == src_w) n_winner = WINNER_NONE;
            end
            OP_CANCEL_ALL: begin
                n_active  = '0;
                n_running = '0;
                n_winner  = WINNER_NONE;
            end
            OP_PAUSE_ON:  n_pause = 1'b1;
            OP_PAUSE_OFF: n_pause = 1'b0;
            OP_PAUSE_TGL: n_pause = !r_pause;
            OP_ESTOP_SET: n_estop = 1'b1;
            OP_ESTOP_CLR: n_estop = 1'b0;
            default: ;
        endcase

        for (int i = 0; i < SOURCES; i++) begin
            if (n_active[i] && n_kind[i] != KIND_NONE) any_elig = 1'b1;
        end
        n_res.winner   = n_winner;
        n_res.paused   = n_pause;
        n_res.estopped = n_estop;
        n_res.idle     = !n_pause && !n_estop && !any_elig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_running <= '0;
            r_kind    <= '{default: KIND_NONE};
            r_winner  <= WINNER_NONE;
            r_pause   <= 1'b0;
            r_estop   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_active  <= n_active;
            r_running <= n_running;
            r_kind    <= n_kind;
            r_winner  <= n_winner;
            r_pause   <= n_pause;
            r_estop   <= n_estop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
            if (n_handle_we) r_handle[i_in_word.source] <= i_in_word.cmd_handle;
        end
    end

    assign o_out_word = r_res;

    a_issue_no_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.issue_valid |-> !r_res.stop_request)
        else $error("dispatch and stop request together");

    a_issue_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.issue_valid |-> r_res.issue_kind != KIND_NONE)
        else $error("dispatched an empty command");

    a_issue_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.issue_valid |-> (r_res.advance_motion || r_res.issue_kind == KIND_STOP))
        else $error("motion step missing on dispatch");

    a_winner_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_winner != WINNER_NONE |-> r_active[r_winner[SRC_W-1:0]])
        else $error("winner slot not active");

endmodule

/* src/preemptive_priority_command_arbiter_unit.sv */
// preemptive priority command arbiter
//
// input channel: i_in_valid / o_in_ready carry one command word (tick,
// submit, cancel, cancel all, pause and estop controls). output channel:
// o_out_valid / i_out_ready carry exactly one result word per command.
// each command is applied to the slot table in the cycle it is accepted
// and its result word is shown from the next cycle.
// throughput is 1 word per cycle while the receiver takes results; the
// single result register is the only buffer, so a new word is taken in
// the same cycle the held result leaves.
// when the receiver stalls, the result word holds and o_in_ready drops
// until it is taken.
// reset (synchronous, active low) clears all slot flags and kinds,
// the pause and estop flags, sets the winner to none and marks the
// result register empty; its word is kept, handles keep theirs until submitted.
// when neither paused nor estopped, ticks pick the highest active source
// with a real command, reporting dispatch, stop request and motion step.
module preemptive_priority_command_arbiter_unit
    import ppca_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_ctl_cmd cmd;

    ppca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ppca_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ppca_pkg::*;

    localparam logic [KIND_W-1:0] KIND_PATH_XY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GOTO_AN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRACK_XY = 3'd5;
    localparam logic [3:0]        OP_UNUSED_TOP = 4'hF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 440;
    localparam int HOLD_WORDS  = 40;

    class arbiter_scoreboard;
        logic                    act  [SOURCES];
        logic                    run  [SOURCES];
        logic [KIND_W-1:0]       kind [SOURCES];
        logic [HANDLE_WIDTH-1:0] hdl  [SOURCES];
        logic [WIN_W-1:0]        win;
        logic                    pau;
        logic                    est;
        t_out_word               due_results[$];
        int                      errors;
        int                      checked;
        int                      dispatches;
        int                      stops;

        function new();
            for (int i = 0; i < SOURCES; i++) begin
                act[i]  = 1'b0;
                run[i]  = 1'b0;
                kind[i] = KIND_NONE;
                hdl[i]  = '0;
            end
            win        = WINNER_NONE;
            pau        = 1'b0;
            est        = 1'b0;
            errors     = 0;
            checked    = 0;
            dispatches = 0;
            stops      = 0;
        endfunction

        function void clear_slot(int s);
            act[s] = 1'b0;
            run[s] = 1'b0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // applies one command word to the slot table and returns its result word
        function t_out_word apply_command(t_in_word w);
            t_out_word r;
            int        best;
            logic      eligible;
            r = '0;
            case (w.opcode)
                OP_TICK: begin
                    if (est || pau) begin
                        if (win != WINNER_NONE) begin
                            r.stop_request = 1'b1;
                            win = WINNER_NONE;
                        end
                        for (int i = 0; i < SOURCES; i++) run[i] = 1'b0;
                    end else begin
                        best = SOURCES;
                        for (int i = 0; i < SOURCES; i++)
                            if (act[i] && kind[i] != KIND_NONE) best = i;
                        if (best == SOURCES) begin
                            r.stop_request   = w.motion_tracking;
                            r.advance_motion = 1'b1;
                            win = WINNER_NONE;
                        end else begin
                            if (win != best || !run[best]) begin
                                r.issue_valid  = 1'b1;
                                r.issue_kind   = kind[best];
                                r.issue_handle = hdl[best];
                                r.issue_source = SRC_W'(best);
                                win = WIN_W'(best);
                                run[best] = 1'b1;
                            end
                            if (kind[best] == KIND_STOP) begin
                                clear_slot(best);
                                win = WINNER_NONE;
                            end else begin
                                r.advance_motion = 1'b1;
                                if (kind[best] >= KIND_GOTO_XY && kind[best] <= KIND_PATH_AN
                                    && w.motion_done) begin
                                    clear_slot(best);
                                    win = WINNER_NONE;
                                end
                            end
                        end
                    end
                end
                OP_SUBMIT: begin
                    if (w.cmd_kind != KIND_BAD) begin
                        if (w.preempt) begin
                            for (int i = 0; i < int'(w.source); i++) clear_slot(i);
                            if (win != WINNER_NONE && win < w.source) win = WINNER_NONE;
                        end
                        kind[w.source] = w.cmd_kind;
                        hdl[w.source]  = w.cmd_handle;
                        act[w.source]  = 1'b1;
                        run[w.source]  = 1'b0;
                    end
                end
                OP_CANCEL: begin
                    clear_slot(int'(w.source));
                    if (win == w.source) win = WINNER_NONE;
                end
                OP_CANCEL_ALL: begin
                    for (int i = 0; i < SOURCES; i++) clear_slot(i);
                    win = WINNER_NONE;
                end
                OP_PAUSE_ON:  pau = 1'b1;
                OP_PAUSE_OFF: pau = 1'b0;
                OP_PAUSE_TGL: pau = !pau;
                OP_ESTOP_SET: est = 1'b1;
                OP_ESTOP_CLR: est = 1'b0;
                default: ;
            endcase
            eligible = 1'b0;
            for (int i = 0; i < SOURCES; i++)
                if (act[i] && kind[i] != KIND_NONE) eligible = 1'b1;
            r.winner   = win;
            r.paused   = pau;
            r.estopped = est;
            r.idle     = !pau && !est && !eligible;
            return r;
        endfunction

        function void note_input(t_in_word w);
            due_results.push_back(apply_command(w));
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_out_word r);
            t_out_word e;
            if (due_results.size() == 0) begin
                $error("result word with no command pending");
                errors++;
                return;
            end
            e = due_results.pop_front();
            checked++;
            if (e.issue_valid) dispatches++;
            if (e.stop_request) stops++;
            cmp("issue_valid", 32'(e.issue_valid), 32'(r.issue_valid));
            cmp("issue_kind", 32'(e.issue_kind), 32'(r.issue_kind));
            cmp("issue_handle", 32'(e.issue_handle), 32'(r.issue_handle));
            cmp("issue_source", 32'(e.issue_source), 32'(r.issue_source));
            cmp("stop_request", 32'(e.stop_request), 32'(r.stop_request));
            cmp("advance_motion", 32'(e.advance_motion), 32'(r.advance_motion));
            cmp("winner", 32'(e.winner), 32'(r.winner));
            cmp("paused", 32'(e.paused), 32'(r.paused));
            cmp("estopped", 32'(e.estopped), 32'(r.estopped));
            cmp("idle", 32'(e.idle), 32'(r.idle));
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    arbiter_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles    = 0;
    int sent      = 0;

    preemptive_priority_command_arbiter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_word);
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_in_word mk(logic [3:0] op, int unsigned src, logic [KIND_W-1:0] k,
                                    logic [HANDLE_WIDTH-1:0] h, logic pre, logic dn,
                                    logic trk);
        t_in_word w;
        w.opcode          = op;
        w.source          = SRC_W'(src);
        w.cmd_kind        = k;
        w.cmd_handle      = h;
        w.preempt         = pre;
        w.motion_done     = dn;
        w.motion_tracking = trk;
        return w;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word    w;
        int unsigned p;
        p = $urandom_range(99);
        w.source          = SRC_W'($urandom_range(SOURCES - 1));
        w.cmd_kind        = ($urandom_range(99) < 5) ? KIND_BAD : KIND_W'($urandom_range(6));
        w.cmd_handle      = HANDLE_WIDTH'($urandom_range(255));
        w.preempt         = ($urandom_range(99) < 25);
        w.motion_done     = ($urandom_range(99) < 30);
        w.motion_tracking = 1'($urandom_range(1));
        if (p < 42)      w.opcode = OP_TICK;
        else if (p < 72) w.opcode = OP_SUBMIT;
        else if (p < 80) w.opcode = OP_CANCEL;
        else if (p < 82) w.opcode = OP_CANCEL_ALL;
        else if (p < 84) w.opcode = OP_PAUSE_ON;
        else if (p < 88) w.opcode = OP_PAUSE_OFF;
        else if (p < 90) w.opcode = OP_PAUSE_TGL;
        else if (p < 92) w.opcode = OP_ESTOP_SET;
        else if (p < 96) w.opcode = OP_ESTOP_CLR;
        else             w.opcode = 4'($urandom_range(15, 9));
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(w);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 81, 0, 18};
        stall_tab = '{0, 0, 81, 18};
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(mk(OP_SUBMIT, 0, KIND_GOTO_XY, 8'h00, 0, 0, 0));
        send_word(mk(OP_SUBMIT, SOURCES - 1, KIND_TRACK_XY, 8'hFF, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_SUBMIT, 3, KIND_PATH_XY, 8'h5A, 1, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 1, 1));
        send_word(mk(OP_CANCEL, SOURCES - 1, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 1, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 1));
        send_word(mk(OP_SUBMIT, 5, KIND_NONE, 8'hA5, 0, 0, 0));
        send_word(mk(OP_SUBMIT, 2, KIND_BAD, 8'h3C, 1, 0, 0));
        send_word(mk(OP_SUBMIT, 4, KIND_STOP, 8'h81, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_SUBMIT, 1, KIND_GOTO_AN, 8'h12, 0, 0, 0));
        send_word(mk(OP_PAUSE_ON, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 1));
        send_word(mk(OP_PAUSE_TGL, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_SUBMIT, 6, KIND_PATH_AN, 8'h7E, 1, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 1, 0));
        send_word(mk(OP_ESTOP_SET, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_TICK, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_ESTOP_CLR, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_UNUSED_TOP, 7, KIND_BAD, 8'hFF, 1, 1, 1));
        send_word(mk(OP_PAUSE_OFF, 0, KIND_NONE, 0, 0, 0, 0));
        send_word(mk(OP_CANCEL_ALL, 0, KIND_NONE, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct <= stall_tab[ph];
            for (int n = 0; n < PHASE_WORDS; n++) send_word(rand_word());
            wait_drained();
            if (ph == 0) begin
                // output held off while input keeps coming
                hold_req <= hold_req + 1;
                for (int n = 0; n < HOLD_WORDS; n++) send_word(rand_word());
                wait_drained();
            end
        end

        idle_pct  = 0;
        stall_pct <= 0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("covered %0d command words: directed cases, four idle/stall mixes, output hold",
                 sent);
        $display("%0d results checked, %0d dispatches, %0d stop requests",
                 sb.checked, sb.dispatches, sb.stops);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
